[rtl/core/sliding_window_iqr_outlier_unit_macros.svh]
// Assertion macros for the sliding window IQR outlier unit.
// Used by the port checker only.
`ifndef SLIDING_WINDOW_IQR_OUTLIER_UNIT_MACROS_SVH
`define SLIDING_WINDOW_IQR_OUTLIER_UNIT_MACROS_SVH
// Implication checked every clock, quiet in reset.
`define SWIQR_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication.
`define SWIQR_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

[rtl/core/swiqr_pkg.sv]
// Package for the sliding window IQR outlier unit: sizes, register codes, types.
// No dependencies.
`default_nettype none
package swiqr_pkg;
    localparam int WindowDepth  = 64;
    localparam int NumChannels  = 16;
    localparam int SlotW        = $clog2(WindowDepth);
    localparam int ChW          = $clog2(NumChannels);
    localparam int CntW         = $clog2(WindowDepth + 1);
    localparam int AddrW        = ChW + SlotW;
    localparam int MemDepth     = NumChannels * WindowDepth;
    localparam int TimeW        = 36;
    localparam int ValW         = 32;
    localparam int EntryW       = TimeW + ValW;
    localparam int CfgIdxW      = 2;
    localparam int CfgDataW     = 16;
    localparam logic [CfgIdxW-1:0] RegWindowLength = 2'd0;
    localparam logic [CfgIdxW-1:0] RegFenceMult    = 2'd1;
    localparam logic [CfgIdxW-1:0] RegMinCount     = 2'd2;
    typedef logic signed [ValW-1:0] t_val;
    typedef logic [TimeW-1:0] t_time;
endpackage
`default_nettype wire

[rtl/core/sliding_window_iqr_outlier_unit.sv]
// Per input beat: expire stale entries of its channel; if the window is then
// non-empty and holds at least the minimum count, load the live entries into
// the rank buffer, insertion-sort them through one compare-write port, gather
// the quartiles and run the fence compare; then write the sample and load the
// output register. One item at a time: tready is low from acceptance until the
// result enters the output register; a result still waiting there holds the
// next item in its last state. Synchronous active-low reset clears the per-channel
// counts and pointers and the output register and restores the register defaults.
// Top level: sequencer, window memory, rank buffer and fence unit.
`default_nettype none
module sliding_window_iqr_outlier_unit import swiqr_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [CfgIdxW-1:0]  i_cfg_idx,
    input  wire logic [CfgDataW-1:0] i_cfg_data,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // channel [3:0], sample_time [39:4], sample_value [71:40]
    input  wire logic [71:0]         s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // is_outlier [0], was_tested [1]
    output logic [7:0]               m_axis_tdata
);
    localparam logic [3:0] StIdle = 4'd0, StExpRd = 4'd1, StExpChk = 4'd2,
        StExpW = 4'd3, StLdRd = 4'd4, StLdW = 4'd5, StLdGet = 4'd6,
        StLdSort = 4'd7, StQ = 4'd8, StQ2 = 4'd9, StFence = 4'd10,
        StWrite = 4'd11, StOut = 4'd12, StFStart = 4'd13;
    logic [3:0]        r_st;
    logic [15:0]       r_wl;
    logic [11:0]       r_k;
    logic [6:0]        r_minc;
    logic [CntW-1:0]   r_fill [NumChannels];
    logic [SlotW-1:0]  r_old  [NumChannels];
    logic [ChW-1:0]    r_ch;
    t_time             r_now;
    t_val              r_x;
    logic [CntW-1:0]   r_n, r_i;
    logic [SlotW-1:0]  r_o;
    logic              r_tested, r_outl;
    logic [33:0]       r_q1, r_q3;
    logic [2:0]        r_qs;
    logic              r_ovalid;
    logic [1:0]        r_obits;
    logic              w_oload;
    logic [SlotW-1:0]  w_ri;
    logic [33:0]       w_rk1, w_rk2;
    logic              mem_we;
    logic [AddrW-1:0]  mem_addr;
    logic [EntryW-1:0] mem_rd;
    logic              rk_clear, rk_load, rk_busy, fc_start, fc_done, fc_out;
    t_val              rk_val;
    logic [CntW-1:0]   w_h, w_lo2;

    swiqr_ram #(.Width(EntryW), .Depth(MemDepth)) u_mem (
        .i_clk(i_clk), .i_we(mem_we), .i_addr(mem_addr),
        .i_wdata({r_now, r_x}), .o_rdata(mem_rd));
    swiqr_rank u_rank (
        .i_clk(i_clk), .i_clear(rk_clear), .i_load(rk_load),
        .i_val(mem_rd[ValW-1:0]), .i_rd_idx(w_ri), .o_rd_val(rk_val),
        .o_busy(rk_busy));
    swiqr_fence u_fence (
        .i_clk(i_clk), .i_start(fc_start), .i_small(r_n < CntW'(4)),
        .i_q1x2(r_q1), .i_q3x2(r_q3), .i_k(r_k), .i_x(r_x),
        .o_done(fc_done), .o_outlier(fc_out));

    assign s_axis_tready = i_rst_n && (r_st == StIdle);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_obits};
    assign w_oload  = (r_st == StOut) && (!r_ovalid || m_axis_tready);
    assign mem_we   = (r_st == StWrite);
    assign rk_clear = (r_st == StIdle);
    assign rk_load  = (r_st == StLdGet);
    assign fc_start = (r_st == StFStart);
    assign w_h   = r_n >> 1;
    assign w_lo2 = w_h + CntW'(r_n[0]);
    assign w_rk1 = 34'(signed'(rk_val));
    assign w_rk2 = {w_rk1[32:0], 1'b0};

    // Rank read address per gather step; its data arrives in the next cycle
    always_comb begin
        case (r_qs)
            3'd0: w_ri = (r_n < CntW'(4)) ? '0 : SlotW'(w_h >> 1);
            3'd1: w_ri = (r_n < CntW'(4)) ? SlotW'(r_n - 1'b1)
                                          : SlotW'((w_h >> 1) - 1'b1);
            3'd2: w_ri = SlotW'(w_lo2 + (w_h >> 1));
            3'd3: w_ri = SlotW'(w_lo2 + (w_h >> 1) - 1'b1);
            default: w_ri = '0;
        endcase
    end

    // Memory address per state
    always_comb begin
        case (r_st)
            StWrite: begin
                mem_addr = {r_ch, (r_fill[r_ch] == CntW'(WindowDepth)) ? r_o
                            : SlotW'(r_o + r_n[SlotW-1:0])};
            end
            StLdRd, StLdW: mem_addr = {r_ch, SlotW'(r_o + r_i[SlotW-1:0])};
            default: mem_addr = {r_ch, r_o};
        endcase
    end

    // Output register: hold the result beat until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_obits  <= '0;
        end else if (w_oload) begin
            r_ovalid <= 1'b1;
            r_obits  <= {r_tested, r_outl};
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= StIdle;
            r_wl   <= 16'd300;
            r_k    <= 12'd384;
            r_minc <= 7'd8;
            r_qs   <= '0;
            for (int c = 0; c < NumChannels; c++) begin
                r_fill[c] <= '0;
                r_old[c]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    RegWindowLength: r_wl   <= i_cfg_data;
                    RegFenceMult:    r_k    <= i_cfg_data[11:0];
                    RegMinCount:     r_minc <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            case (r_st)
                StIdle: if (s_axis_tvalid) begin
                    r_ch  <= s_axis_tdata[ChW-1:0];
                    r_now <= s_axis_tdata[39:4];
                    r_x   <= s_axis_tdata[71:40];
                    r_o   <= r_old[s_axis_tdata[ChW-1:0]];
                    r_n   <= r_fill[s_axis_tdata[ChW-1:0]];
                    r_st  <= StExpRd;
                end
                StExpRd: r_st <= (r_n == '0) ? StExpW : StExpChk;
                StExpChk: begin
                    if (37'(mem_rd[EntryW-1:ValW]) + 37'(r_wl) < 37'(r_now)) begin
                        r_o  <= r_o + 1'b1;
                        r_n  <= r_n - 1'b1;
                        r_st <= StExpRd;
                    end else begin
                        r_st <= StExpW;
                    end
                end
                StExpW: begin
                    r_old[r_ch]  <= r_o;
                    r_fill[r_ch] <= r_n;
                    r_i          <= '0;
                    r_outl       <= 1'b0;
                    r_tested     <= (r_n != '0) && (7'(r_n) >= r_minc);
                    r_st <= ((r_n != '0) && (7'(r_n) >= r_minc)) ? StLdRd : StWrite;
                end
                StLdRd: r_st <= StLdW;
                StLdW:  r_st <= StLdGet;
                StLdGet: begin
                    r_i  <= r_i + 1'b1;
                    r_st <= StLdSort;
                end
                StLdSort: if (!rk_busy) begin
                    r_st <= (r_i == r_n) ? StQ : StLdRd;
                end
                StQ: begin
                    r_qs <= '0;
                    r_q1 <= '0;
                    r_q3 <= '0;
                    r_st <= StQ2;
                end
                StQ2: begin
                    // Gather doubled quartiles, one rank read per cycle
                    r_qs <= r_qs + 1'b1;
                    if (r_n < CntW'(4)) begin
                        case (r_qs)
                            3'd1: r_q1 <= w_rk2;
                            3'd2: begin
                                r_q3 <= w_rk2;
                                r_st <= StFStart;
                            end
                            default: ;
                        endcase
                    end else begin
                        case (r_qs)
                            3'd1: r_q1 <= w_h[0] ? w_rk2 : w_rk1;
                            3'd2: if (!w_h[0]) r_q1 <= r_q1 + w_rk1;
                            3'd3: r_q3 <= w_h[0] ? w_rk2 : w_rk1;
                            3'd4: begin
                                if (!w_h[0]) r_q3 <= r_q3 + w_rk1;
                                r_st <= StFStart;
                            end
                            default: ;
                        endcase
                    end
                end
                StFStart: r_st <= StFence;
                StFence: if (fc_done) begin
                    r_outl <= fc_out;
                    r_st   <= StWrite;
                end
                StWrite: begin
                    if (r_n == CntW'(WindowDepth)) begin
                        r_old[r_ch] <= r_o + 1'b1;
                    end else begin
                        r_fill[r_ch] <= r_n + 1'b1;
                    end
                    r_st <= StOut;
                end
                StOut: if (w_oload) r_st <= StIdle;
                default: r_st <= StIdle;
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/core/swiqr_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module swiqr_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_addr,
    input  wire logic [Width-1:0]         i_wdata,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    // Write or read one word per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

[rtl/core/swiqr_rank.sv]
// Rank buffer: holds the channel's live window values in a small RAM and sorts
// them by insertion, one read or one compare-and-write per cycle. Uses swiqr_pkg, swiqr_ram.
`default_nettype none
module swiqr_rank import swiqr_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_clear,
    input  wire logic             i_load,
    input  wire t_val             i_val,
    input  wire logic [SlotW-1:0] i_rd_idx,
    output t_val                  o_rd_val,
    output logic                  o_busy
);
    logic [CntW-1:0]  r_n;
    logic [SlotW-1:0] r_j;
    logic             r_ins;
    logic             r_cmp;
    t_val             r_v;
    logic             w_we;
    logic [SlotW-1:0] w_addr;
    t_val             w_wdata;
    t_val             w_rd;
    logic             w_move;

    swiqr_ram #(.Width(ValW), .Depth(WindowDepth)) u_buf (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr),
        .i_wdata(w_wdata), .o_rdata(w_rd));

    assign o_busy   = r_ins;
    assign o_rd_val = w_rd;
    // Read slot j-1, then compare it and shift it up or drop the new value in
    assign w_move  = r_cmp && (w_rd > r_v);
    assign w_we    = r_ins && (r_cmp || (r_j == '0));
    assign w_wdata = w_move ? w_rd : r_v;
    assign w_addr  = (r_ins && !r_cmp && (r_j != '0)) ? SlotW'(r_j - 1'b1)
                   : (r_ins ? r_j : i_rd_idx);

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_n   <= '0;
            r_ins <= 1'b0;
            r_cmp <= 1'b0;
        end else if (i_load) begin
            r_v   <= i_val;
            r_j   <= r_n[SlotW-1:0];
            r_ins <= 1'b1;
            r_cmp <= 1'b0;
        end else if (r_ins) begin
            if (!r_cmp) begin
                if (r_j == '0) begin
                    r_n   <= r_n + 1'b1;
                    r_ins <= 1'b0;
                end else begin
                    r_cmp <= 1'b1;
                end
            end else if (w_move) begin
                r_j   <= r_j - 1'b1;
                r_cmp <= 1'b0;
            end else begin
                r_n   <= r_n + 1'b1;
                r_ins <= 1'b0;
                r_cmp <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

[rtl/core/swiqr_fence.sv]
// Fence arithmetic: multi-cycle compare of the sample against the Tukey
// fences (quartiles if i_small), one multiply per run. Uses swiqr_pkg.
`default_nettype none
module swiqr_fence import swiqr_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_start,
    input  wire logic        i_small,
    input  wire logic [33:0] i_q1x2,
    input  wire logic [33:0] i_q3x2,
    input  wire logic [11:0] i_k,
    input  wire t_val        i_x,
    output logic             o_done,
    output logic             o_outlier
);
    logic [1:0]         r_step;
    logic signed [34:0] r_iqr;
    logic signed [47:0] r_spread;
    logic signed [49:0] w_lo, w_hi, w_xs;
    assign w_xs = 50'(signed'(i_x)) <<< 9;
    assign w_lo = (50'(signed'(i_q1x2)) <<< 8) - 50'(r_spread);
    assign w_hi = (50'(signed'(i_q3x2)) <<< 8) + 50'(r_spread);
    // Sequence: IQR, multiply, compare
    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (i_start) begin
            r_iqr  <= 35'(signed'(i_q3x2)) - 35'(signed'(i_q1x2));
            r_step <= 2'd1;
        end else if (r_step == 2'd1) begin
            r_spread <= 48'(r_iqr) * signed'({1'b0, i_k});
            r_step   <= 2'd2;
        end else if (r_step == 2'd2) begin
            if (i_small) begin
                o_outlier <= (w_xs < (50'(signed'(i_q1x2)) <<< 8))
                          || (w_xs > (50'(signed'(i_q3x2)) <<< 8));
            end else begin
                o_outlier <= (w_xs < w_lo) || (w_xs > w_hi);
            end
            o_done <= 1'b1;
            r_step <= 2'd0;
        end else begin
            r_step <= 2'd0;
        end
    end
endmodule
`default_nettype wire

[rtl/core/swiqr_checker.sv]
// Port checker for the sliding window IQR outlier unit, bound to the top level.
// Uses the assertion macro header.
`default_nettype none
`include "sliding_window_iqr_outlier_unit_macros.svh"
module swiqr_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata
);
    // Untested beats never flag
    `SWIQR_ASSERT_IMP(a_untested, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[1], !m_axis_tdata[0])
    // Accepted input drops ready next cycle
    `SWIQR_ASSERT_NXT(a_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // A stalled result holds
    `SWIQR_ASSERT_NXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule
bind sliding_window_iqr_outlier_unit swiqr_checker u_chk (.*);
`default_nettype wire
